// ===== sv/tcw_pkg.sv =====
// shared constants, operation codes and controller/datapath interface types
`default_nettype none

package tcw_pkg;

  // default grid size
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // field widths fixed by the stream format
  localparam int FUNC_W   = 2;
  localparam int CHAR_W   = 8;
  localparam int ATTR_W   = 8;
  localparam int CELLX_W  = 7;
  localparam int CELLY_W  = 5;
  localparam int CROW_W   = 5;
  localparam int CCOL_W   = 7;
  localparam int CIDX_W   = 11;
  localparam int CELL_W   = 16;
  localparam int IN_DW    = 32;
  localparam int OUT_DW   = 40;

  // operation codes carried on in_tuser
  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd3;

  // character and cell constants
  localparam logic [CHAR_W-1:0] LINE_FEED    = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'd32;
  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;
  localparam logic [ATTR_W-1:0] ATTRIB_RESET = 8'h07;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic put;
    logic cell_wr;
    logic cell_rd;
    logic clr_step;
    logic blank_step;
    logic sweep_zero;
    logic home;
    logic load_out;
  } tcw_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              scroll_req;
    logic              clr_last;
    logic              blank_last;
    logic              out_free;
  } tcw_sts_t;

endpackage

`default_nettype wire

// ===== sv/tcw_ram.sv =====
// generic single write port, single read port ram with registered read data
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== sv/tcw_ctrl.sv =====
// sequencing state machine: accept, execute, scroll blanking, clearing pass, result hand-off
`default_nettype none

module tcw_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire tcw_pkg::tcw_sts_t sts,
  output tcw_pkg::tcw_cmd_t     cmd
);
  import tcw_pkg::*;

  localparam logic [2:0] S_CLR    = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_BLANK  = 3'd3;
  localparam logic [2:0] S_RDWAIT = 3'd4;
  localparam logic [2:0] S_RESP   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       clr_op_r, clr_op_nxt;

  assign in_tready = (state_r == S_IDLE);

  // next state and command decode
  always_comb begin
    state_nxt  = state_r;
    clr_op_nxt = clr_op_r;
    cmd        = '0;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          clr_op_nxt = 1'b0;
          state_nxt  = clr_op_r ? S_RESP : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts.func)
          FUNC_PUT: begin
            cmd.put = 1'b1;
            if (sts.scroll_req) begin
              cmd.sweep_zero = 1'b1;
              state_nxt      = S_BLANK;
            end else if (sts.out_free) begin
              cmd.load_out = 1'b1;
              state_nxt    = S_IDLE;
            end else begin
              state_nxt = S_RESP;
            end
          end
          FUNC_CLEAR: begin
            cmd.home       = 1'b1;
            cmd.sweep_zero = 1'b1;
            clr_op_nxt     = 1'b1;
            state_nxt      = S_CLR;
          end
          FUNC_WRITE: begin
            cmd.cell_wr = 1'b1;
            if (sts.out_free) begin
              cmd.load_out = 1'b1;
              state_nxt    = S_IDLE;
            end else begin
              state_nxt = S_RESP;
            end
          end
          FUNC_READ: begin
            cmd.cell_rd = 1'b1;
            state_nxt   = S_RDWAIT;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_BLANK: begin
        cmd.blank_step = 1'b1;
        if (sts.blank_last) begin
          state_nxt = S_RESP;
        end
      end
      S_RDWAIT, S_RESP: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_RESP;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  // state registers; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      clr_op_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_op_r <= clr_op_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/tcw_dp.sv =====
// datapath: captured transaction, cursor and row ring offset, cell ram, result register
`default_nettype none

module tcw_dp #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [tcw_pkg::IN_DW-1:0]   in_tdata,
  input  wire logic [tcw_pkg::FUNC_W-1:0]  in_tuser,
  input  wire logic                        cfg_valid,
  input  wire logic [tcw_pkg::ATTR_W-1:0]  cfg_data,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic      [tcw_pkg::OUT_DW-1:0]  out_tdata,
  input  wire tcw_pkg::tcw_cmd_t           cmd,
  output tcw_pkg::tcw_sts_t                sts
);
  import tcw_pkg::*;

  localparam int TOTAL  = COLUMNS * ROWS;
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(TOTAL);
  localparam int MW     = ADDR_W + 8;

  // captured transaction
  logic [FUNC_W-1:0]  func_r, func_nxt;
  logic [CHAR_W-1:0]  char_r, char_nxt;
  logic [ATTR_W-1:0]  attr_r, attr_nxt;
  logic [CELLX_W-1:0] x_r, x_nxt;
  logic [CELLY_W-1:0] y_r, y_nxt;

  // cursor, ring offset of the top row, sweep counter, attribute register
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  top_r, top_nxt;
  logic [ADDR_W-1:0] sweep_r, sweep_nxt;
  logic [ATTR_W-1:0] attrib_r, attrib_nxt;

  // result register
  logic              ovalid_r, ovalid_nxt;
  logic [CROW_W-1:0] orow_r, orow_nxt;
  logic [CCOL_W-1:0] ocol_r, ocol_nxt;
  logic [CIDX_W-1:0] oidx_r, oidx_nxt;
  logic [CELL_W-1:0] ocell_r, ocell_nxt;

  logic              is_lf, line_end, row_last, newline, on_grid;
  logic [ROW_W-1:0]  top_wrap;
  logic [ROW_W:0]    lrow_sel, phys_sum, phys_row;
  logic [MW-1:0]     lcol_sel, row_addr_w, cur_idx_w;
  logic [ADDR_W-1:0] row_addr;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  // decode of the held transaction and cursor
  assign is_lf    = (char_r == LINE_FEED);
  assign line_end = (col_r == COL_W'(COLUMNS - 1));
  assign row_last = (row_r == ROW_W'(ROWS - 1));
  assign newline  = is_lf || line_end;
  assign on_grid  = ({2'b00, x_r} < 9'(COLUMNS)) && ({3'b000, y_r} < 8'(ROWS));
  assign top_wrap = (top_r == ROW_W'(ROWS - 1)) ? '0 : top_r + 1'b1;

  // logical row and column select for the cell address
  always_comb begin
    priority if (cmd.blank_step) begin
      lrow_sel = (ROW_W+1)'(ROWS - 1);
      lcol_sel = MW'(sweep_r);
    end else if (cmd.put) begin
      lrow_sel = {1'b0, row_r};
      lcol_sel = MW'(col_r);
    end else begin
      lrow_sel = (ROW_W+1)'(y_r);
      lcol_sel = MW'(x_r);
    end
  end

  // map the logical row through the ring offset, then form the linear address
  assign phys_sum   = lrow_sel + {1'b0, top_r};
  assign phys_row   = (phys_sum >= (ROW_W+1)'(ROWS)) ? phys_sum - (ROW_W+1)'(ROWS) : phys_sum;
  assign row_addr_w = MW'(phys_row) * MW'(COLUMNS) + lcol_sel;
  assign row_addr   = row_addr_w[ADDR_W-1:0];

  // logical cursor index after the operation, for the result register
  assign cur_idx_w = MW'(row_nxt) * MW'(COLUMNS) + MW'(col_nxt);

  // ram write port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = row_addr;
    ram_wdata = {attrib_r, char_r};
    priority if (cmd.clr_step) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_r;
      ram_wdata = BLANK_CELL;
    end else if (cmd.blank_step) begin
      ram_we    = 1'b1;
      ram_wdata = {attrib_r, SPACE_CHAR};
    end else if (cmd.put) begin
      ram_we    = !is_lf;
    end else if (cmd.cell_wr) begin
      ram_we    = on_grid;
      ram_wdata = {attr_r, char_r};
    end else begin
      ram_we    = 1'b0;
    end
  end

  assign ram_re = cmd.cell_rd && on_grid;

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (TOTAL)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (row_addr),
    .rdata (ram_rdata)
  );

  // next values of the datapath registers
  always_comb begin
    func_nxt   = func_r;
    char_nxt   = char_r;
    attr_nxt   = attr_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    top_nxt    = top_r;
    sweep_nxt  = sweep_r;
    attrib_nxt = cfg_valid ? cfg_data : attrib_r;

    // capture the input transaction
    if (cmd.capture) begin
      func_nxt = in_tuser;
      char_nxt = in_tdata[7:0];
      attr_nxt = in_tdata[15:8];
      x_nxt    = in_tdata[22:16];
      y_nxt    = in_tdata[27:23];
    end

    // cursor advance, new line and scroll by moving the ring offset
    if (cmd.put) begin
      if (newline) begin
        col_nxt = '0;
        if (row_last) begin
          top_nxt = top_wrap;
        end else begin
          row_nxt = row_r + 1'b1;
        end
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end

    if (cmd.home) begin
      row_nxt = '0;
      col_nxt = '0;
      top_nxt = '0;
    end

    // sweep counter for clearing pass and row blanking
    priority if (cmd.sweep_zero) begin
      sweep_nxt = '0;
    end else if (cmd.clr_step || cmd.blank_step) begin
      sweep_nxt = sweep_r + 1'b1;
    end else begin
      sweep_nxt = sweep_r;
    end
  end

  // result register loads when free, drains on the output transaction
  always_comb begin
    ovalid_nxt = ovalid_r;
    orow_nxt   = orow_r;
    ocol_nxt   = ocol_r;
    oidx_nxt   = oidx_r;
    ocell_nxt  = ocell_r;
    if (cmd.load_out) begin
      ovalid_nxt = 1'b1;
      orow_nxt   = CROW_W'(row_nxt);
      ocol_nxt   = CCOL_W'(col_nxt);
      oidx_nxt   = CIDX_W'(cur_idx_w);
      ocell_nxt  = (func_r == FUNC_READ && on_grid) ? ram_rdata : '0;
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r    <= '0;
      col_r    <= '0;
      top_r    <= '0;
      sweep_r  <= '0;
      attrib_r <= ATTRIB_RESET;
      ovalid_r <= 1'b0;
    end else begin
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      top_r    <= top_nxt;
      sweep_r  <= sweep_nxt;
      attrib_r <= attrib_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    func_r  <= func_nxt;
    char_r  <= char_nxt;
    attr_r  <= attr_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    orow_r  <= orow_nxt;
    ocol_r  <= ocol_nxt;
    oidx_r  <= oidx_nxt;
    ocell_r <= ocell_nxt;
  end

  // status to the controller
  always_comb begin
    sts            = '0;
    sts.func       = func_r;
    sts.scroll_req = newline && row_last;
    sts.clr_last   = (sweep_r == ADDR_W'(TOTAL - 1));
    sts.blank_last = (sweep_r == ADDR_W'(COLUMNS - 1));
    sts.out_free   = !ovalid_r || out_tready;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {1'b0, ocell_r, oidx_r, ocol_r, orow_r};

endmodule

`default_nettype wire

// ===== sv/text_console_writer.sv =====
// Text console writer over a COLUMNS x ROWS grid of 16-bit cells (attribute high byte,
// character low byte), kept in one single-write-port ram whose rows form a ring so that
// a scroll only moves the top-row offset and blanks one row. After reset the block runs a
// clearing pass over all COLUMNS*ROWS cells (2000 by default) with in_tready low; cfg writes
// are taken throughout. Read cell passes through a wait state for the registered ram read.
// A put character that scrolls goes on to blank the new bottom row, one cell a cycle on the
// ram write port, and clear screen sweeps every cell the same way. One transaction is in
// work at a time; a finished result waits in the output register while the next one is
// accepted.
`default_nettype none

module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input stream
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  // char_code[7:0], cell_attrib[15:8], cell_x[22:16], cell_y[27:23], zero[31:28]
  input  wire logic [tcw_pkg::IN_DW-1:0]   in_tdata,
  // func[1:0]
  input  wire logic [tcw_pkg::FUNC_W-1:0]  in_tuser,
  // result stream
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // cursor_row[4:0], cursor_col[11:5], cursor_index[22:12], cell_value[38:23], zero[39]
  output logic      [tcw_pkg::OUT_DW-1:0]  out_tdata,
  // text_attrib register write
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [tcw_pkg::ATTR_W-1:0]  cfg_data
);
  import tcw_pkg::*;

  tcw_cmd_t cmd;
  tcw_sts_t sts;

  assign cfg_ready = 1'b1;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcw_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

`default_nettype wire

// ===== sv/tcw_checker.sv =====
// port-level checks on the console writer and the bind that attaches them
`default_nettype none

module tcw_checker #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_tready,
  input wire logic                       out_tvalid,
  input wire logic                       out_tready,
  input wire logic [tcw_pkg::OUT_DW-1:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // reset starts the clearing pass with nothing pending
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("block not quiet after reset");

  // reported cursor lies on the grid
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[11:5] < COLUMNS) && (out_tdata[4:0] < ROWS))
    else $error("cursor off the grid");

  // linear index agrees with row and column
  a_cursor_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (ROWS <= 32) && (COLUMNS <= 128) |->
      out_tdata[22:12] == 11'(out_tdata[4:0] * COLUMNS + out_tdata[11:5]))
    else $error("cursor index mismatch");

endmodule

bind text_console_writer tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ===== tb/text_console_writer_tb.sv =====
// testbench for the text console writer: directed and random streams checked against a grid predictor
module text_console_writer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam int COLS        = DEF_COLUMNS;
  localparam int LINES       = DEF_ROWS;
  localparam int CELLS       = COLS * LINES;
  localparam int CYCLE_LIMIT = 1_000_000;

  // one cursor report with the fields carried on out_tdata
  typedef struct packed {
    logic [CROW_W-1:0] row;
    logic [CCOL_W-1:0] col;
    logic [CIDX_W-1:0] index;
    logic [CELL_W-1:0] cell_val;
  } cursor_report_t;

  logic                clk;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [IN_DW-1:0]    in_tdata   = '0;
  logic [FUNC_W-1:0]   in_tuser   = FUNC_PUT;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_DW-1:0]   out_tdata;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic [ATTR_W-1:0]   cfg_data   = '0;

  // predicted console state
  logic [CELL_W-1:0]   shadow_grid [CELLS];
  int unsigned         shadow_row;
  int unsigned         shadow_col;
  logic [ATTR_W-1:0]   shadow_attrib;
  cursor_report_t      expected_reports [$];

  int unsigned         fail_count = 0;
  int unsigned         cycle_count;
  bit                  steady = 1'b0;

  text_console_writer #(
    .COLUMNS (COLS),
    .ROWS    (LINES)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // blank grid, cursor home
  function automatic void home_console();
    for (int i = 0; i < CELLS; i++) shadow_grid[i] = BLANK_CELL;
    shadow_row = 0;
    shadow_col = 0;
  endfunction

  // new line, scrolling the grid up when past the bottom row
  function automatic void advance_line();
    shadow_col = 0;
    shadow_row++;
    if (shadow_row >= LINES) begin
      for (int i = 0; i < CELLS - COLS; i++) shadow_grid[i] = shadow_grid[i + COLS];
      shadow_row = LINES - 1;
      for (int x = 0; x < COLS; x++) shadow_grid[shadow_row * COLS + x] = {shadow_attrib, SPACE_CHAR};
    end
  endfunction

  // apply one operation to the predicted console and form its report
  function automatic cursor_report_t console_step(input logic [FUNC_W-1:0] func,
                                                  input logic [CHAR_W-1:0] ch,
                                                  input logic [ATTR_W-1:0] at,
                                                  input logic [CELLX_W-1:0] x,
                                                  input logic [CELLY_W-1:0] y);
    cursor_report_t rpt;
    logic on_grid;
    on_grid = (x < COLS) && (y < LINES);
    rpt.cell_val = '0;
    case (func)
      FUNC_PUT: begin
        if (ch == LINE_FEED) begin
          advance_line();
        end else begin
          shadow_grid[shadow_row * COLS + shadow_col] = {shadow_attrib, ch};
          shadow_col++;
          if (shadow_col >= COLS) advance_line();
        end
      end
      FUNC_CLEAR: home_console();
      FUNC_WRITE: begin
        if (on_grid) shadow_grid[y * COLS + x] = {at, ch};
      end
      FUNC_READ: begin
        if (on_grid) rpt.cell_val = shadow_grid[y * COLS + x];
      end
    endcase
    rpt.row   = CROW_W'(shadow_row);
    rpt.col   = CCOL_W'(shadow_col);
    rpt.index = CIDX_W'(shadow_row * COLS + shadow_col);
    return rpt;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    fail_count++;
  endtask

  // send one transaction and record its predicted report once accepted
  task automatic send_item(input logic [FUNC_W-1:0] func, input logic [CHAR_W-1:0] ch,
                           input logic [ATTR_W-1:0] at, input logic [CELLX_W-1:0] x,
                           input logic [CELLY_W-1:0] y);
    while (!steady && $urandom_range(99) < 6) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {4'b0, y, x, at, ch};
    do @(posedge clk); while (!in_tready);
    expected_reports.push_back(console_step(func, ch, at, x, y));
  endtask

  // hold the sender until every predicted report has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_reports.size() != 0);
  endtask

  task automatic set_text_attrib(input logic [ATTR_W-1:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    shadow_attrib = value;
    cfg_valid <= 1'b0;
  endtask

  // random character that is not a line feed
  function automatic logic [CHAR_W-1:0] plain_char();
    logic [CHAR_W-1:0] ch;
    ch = CHAR_W'($urandom_range(255));
    return (ch == LINE_FEED) ? SPACE_CHAR : ch;
  endfunction

  // write cell and read cell at the grid corners and outside it
  task automatic test_cell_access();
    send_item(FUNC_WRITE, 8'h00, 8'h00, 7'd0, 5'd0);
    send_item(FUNC_WRITE, 8'hFF, 8'hFF, 7'd79, 5'd24);
    send_item(FUNC_WRITE, 8'h55, 8'hAA, 7'd79, 5'd0);
    send_item(FUNC_WRITE, 8'hAA, 8'h55, 7'd0, 5'd24);
    send_item(FUNC_WRITE, 8'h41, 8'h1E, 7'd80, 5'd0);
    send_item(FUNC_WRITE, 8'h42, 8'h1E, 7'd127, 5'd31);
    send_item(FUNC_WRITE, 8'h43, 8'h1E, 7'd0, 5'd25);
    send_item(FUNC_READ, 8'hFF, 8'hFF, 7'd0, 5'd0);
    send_item(FUNC_READ, 8'h00, 8'h00, 7'd79, 5'd24);
    send_item(FUNC_READ, 8'h00, 8'h00, 7'd79, 5'd0);
    send_item(FUNC_READ, 8'h00, 8'h00, 7'd0, 5'd24);
    send_item(FUNC_READ, 8'h00, 8'h00, 7'd80, 5'd0);
    send_item(FUNC_READ, 8'h00, 8'h00, 7'd127, 5'd31);
    send_item(FUNC_READ, 8'h00, 8'h00, 7'd5, 5'd25);
    send_item(FUNC_READ, 8'h00, 8'h00, 7'd0, 5'd1);
  endtask

  // put character with extreme bytes and a line feed, then read cells of the top row
  task automatic test_put_chars();
    send_item(FUNC_PUT, 8'h41, 8'h00, 7'd0, 5'd0);
    send_item(FUNC_PUT, 8'h00, 8'hFF, 7'd127, 5'd31);
    send_item(FUNC_PUT, 8'hFF, 8'h00, 7'd0, 5'd0);
    send_item(FUNC_PUT, 8'h80, 8'h00, 7'd0, 5'd0);
    send_item(FUNC_PUT, LINE_FEED, 8'h00, 7'd0, 5'd0);
    send_item(FUNC_READ, 8'h00, 8'h00, 7'd0, 5'd0);
    send_item(FUNC_READ, 8'h00, 8'h00, 7'd2, 5'd0);
    send_item(FUNC_READ, 8'h00, 8'h00, 7'd3, 5'd0);
    send_item(FUNC_READ, 8'h00, 8'h00, 7'd4, 5'd0);
  endtask

  // clear screen ignores the configured attribute and homes the cursor
  task automatic test_clear();
    send_item(FUNC_CLEAR, 8'h00, 8'h00, 7'd0, 5'd0);
    send_item(FUNC_READ, 8'h00, 8'h00, 7'd0, 5'd0);
    send_item(FUNC_READ, 8'h00, 8'h00, 7'd79, 5'd24);
  endtask

  // line wrap and scrolling past the bottom row
  task automatic test_scroll();
    send_item(FUNC_CLEAR, 8'h00, 8'h00, 7'd0, 5'd0);
    repeat (COLS + 5) send_item(FUNC_PUT, plain_char(), 8'h00, 7'd0, 5'd0);
    repeat (LINES + 2) begin
      send_item(FUNC_PUT, plain_char(), 8'h00, 7'd0, 5'd0);
      send_item(FUNC_PUT, LINE_FEED, 8'h00, 7'd0, 5'd0);
    end
    for (int x = 0; x < 3; x++) begin
      send_item(FUNC_READ, 8'h00, 8'h00, CELLX_W'(x), 5'd24);
      send_item(FUNC_READ, 8'h00, 8'h00, CELLX_W'(x), 5'd23);
      send_item(FUNC_READ, 8'h00, 8'h00, CELLX_W'(x), 5'd0);
    end
    repeat (COLS + 3) send_item(FUNC_PUT, plain_char(), 8'h00, 7'd0, 5'd0);
    send_item(FUNC_READ, 8'h00, 8'h00, 7'd0, 5'd23);
    send_item(FUNC_READ, 8'h00, 8'h00, 7'd79, 5'd23);
    send_item(FUNC_READ, 8'h00, 8'h00, 7'd79, 5'd24);
  endtask

  // random mix, mostly printing with reads near the cursor and write/read pairs
  task automatic test_random(input int unsigned count, input int unsigned lf_pct);
    logic [FUNC_W-1:0]  func;
    logic [CHAR_W-1:0]  ch;
    logic [ATTR_W-1:0]  at;
    logic [CELLX_W-1:0] x;
    logic [CELLY_W-1:0] y;
    int unsigned        pick;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 2) drain_results();
      pick = $urandom_range(999);
      ch   = CHAR_W'($urandom_range(255));
      at   = ATTR_W'($urandom_range(255));
      x    = CELLX_W'($urandom_range(COLS - 1));
      y    = CELLY_W'($urandom_range(LINES - 1));
      if ($urandom_range(9) == 0) begin
        x = CELLX_W'($urandom_range(127));
        y = CELLY_W'($urandom_range(31));
      end
      if (pick < 4) begin
        func = FUNC_CLEAR;
      end else if (pick < 560) begin
        func = FUNC_PUT;
        if ($urandom_range(99) < lf_pct) ch = LINE_FEED;
      end else if (pick < 730) begin
        func = FUNC_WRITE;
      end else begin
        func = FUNC_READ;
        if ($urandom_range(1) == 1) begin
          y = CELLY_W'(shadow_row - $urandom_range(shadow_row < 2 ? shadow_row : 2));
          x = CELLX_W'($urandom_range(COLS - 1));
        end
      end
      send_item(func, ch, at, x, y);
      if (func == FUNC_WRITE && $urandom_range(1) == 1) begin
        send_item(FUNC_READ, CHAR_W'($urandom_range(255)), ATTR_W'($urandom_range(255)), x, y);
        n++;
      end
    end
  endtask

  // result side stalls
  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 6);
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin : result_check
    cursor_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_reports.size() == 0) begin
        report_mismatch("result with nothing expected", out_tdata, 0);
      end else begin
        want = expected_reports.pop_front();
        if (out_tdata[4:0] !== want.row)
          report_mismatch("cursor_row", out_tdata[4:0], want.row);
        if (out_tdata[11:5] !== want.col)
          report_mismatch("cursor_col", out_tdata[11:5], want.col);
        if (out_tdata[22:12] !== want.index)
          report_mismatch("cursor_index", out_tdata[22:12], want.index);
        if (out_tdata[38:23] !== want.cell_val)
          report_mismatch("cell_value", out_tdata[38:23], want.cell_val);
      end
    end
  end

  // run limit
  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  // test sequence
  initial begin
    home_console();
    shadow_attrib = ATTRIB_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    set_text_attrib(8'hFF);
    test_cell_access();
    test_put_chars();
    set_text_attrib(8'h00);
    test_clear();
    set_text_attrib(8'h5A);
    test_scroll();

    set_text_attrib(ATTRIB_RESET);
    test_random(260, 30);
    set_text_attrib(8'hFF);
    test_random(260, 3);
    set_text_attrib(ATTR_W'($urandom_range(255)));
    steady = 1'b1;
    test_random(260, 20);
    steady = 1'b0;
    set_text_attrib(8'h00);
    test_random(260, 30);
    set_text_attrib(ATTR_W'($urandom_range(255)));
    test_random(260, 5);
    set_text_attrib(8'h80);
    test_random(260, 25);

    // let the last results arrive, then watch for strays
    drain_results();
    repeat (2 * COLS + 20) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/tcw_pkg.sv
sv/tcw_ram.sv
sv/tcw_ctrl.sv
sv/tcw_dp.sv
sv/text_console_writer.sv
sv/tcw_checker.sv
tb/text_console_writer_tb.sv
